### rtl/frpg_pkg.sv
`default_nettype none

package frpg_pkg;

  localparam int unsigned VERTEX_ID_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF    = 2;

  localparam logic KIND_TRI  = 1'b0;
  localparam logic KIND_QUAD = 1'b1;

  // Source of one vertex of a sub-face: a corner, an edge vertex, the center or zero.
  typedef logic [3:0] src_t;

  localparam src_t SRC_V_BASE = 4'd0;
  localparam src_t SRC_E_BASE = 4'd4;
  localparam src_t SRC_CTR    = 4'd8;
  localparam src_t SRC_ZERO   = 4'd9;

  typedef struct packed {
    logic           quad;
    logic           center_used;
    logic           status;
    src_t [3:0]     src;
  } sub_t;

  typedef struct packed {
    logic [1:0]     last_idx;
    sub_t [3:0]     sub;
  } plan_t;

  localparam int unsigned PLAN_BITS = $bits(plan_t);

  function automatic src_t src_v(input logic [1:0] idx);
    return SRC_V_BASE | {2'b00, idx};
  endfunction

  function automatic src_t src_e(input logic [1:0] idx);
    return SRC_E_BASE | {2'b00, idx};
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : 2'(x + 2'd1);
  endfunction

  function automatic sub_t mk_tri(input src_t a, input src_t b, input src_t c);
    sub_t r;
    r.quad        = 1'b0;
    r.center_used = 1'b0;
    r.status      = 1'b0;
    r.src[0]      = a;
    r.src[1]      = b;
    r.src[2]      = c;
    r.src[3]      = SRC_ZERO;
    return r;
  endfunction

  function automatic sub_t mk_quad(input src_t a, input src_t b, input src_t c,
                                   input src_t d, input logic cu);
    sub_t r;
    r.quad        = 1'b1;
    r.center_used = cu;
    r.status      = 1'b0;
    r.src[0]      = a;
    r.src[1]      = b;
    r.src[2]      = c;
    r.src[3]      = d;
    return r;
  endfunction

  function automatic sub_t mk_fail();
    sub_t r;
    r.quad        = 1'b0;
    r.center_used = 1'b0;
    r.status      = 1'b1;
    r.src[0]      = SRC_ZERO;
    r.src[1]      = SRC_ZERO;
    r.src[2]      = SRC_ZERO;
    r.src[3]      = SRC_ZERO;
    return r;
  endfunction

  // Classifies one face into the list of sub-faces that replace it.
  function automatic plan_t plan_f(input logic kind, input logic [3:0] mask,
                                   input logic cgiven);
    plan_t      p;
    logic [3:0] m;
    logic [2:0] cnt;
    logic [1:0] lo_set;
    logic [1:0] hi_set;
    logic [1:0] lo_clr;
    logic [1:0] n;
    logic [1:0] a;
    logic [1:0] b;
    logic [1:0] s;
    logic [1:0] i0;
    logic [1:0] i1;
    logic       opp;
    src_t       c0;
    src_t       c1;
    src_t       c2;
    src_t       c3;
    src_t       x;
    src_t       y;
    src_t       z;

    m   = (kind == KIND_QUAD) ? mask : {1'b0, mask[2:0]};
    cnt = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);

    if (m[0])      lo_set = 2'd0;
    else if (m[1]) lo_set = 2'd1;
    else if (m[2]) lo_set = 2'd2;
    else           lo_set = 2'd3;

    if (m[3])      hi_set = 2'd3;
    else if (m[2]) hi_set = 2'd2;
    else if (m[1]) hi_set = 2'd1;
    else           hi_set = 2'd0;

    if (!m[0])      lo_clr = 2'd0;
    else if (!m[1]) lo_clr = 2'd1;
    else if (!m[2]) lo_clr = 2'd2;
    else            lo_clr = 2'd3;

    p.last_idx = 2'd0;
    for (int k = 0; k < 4; k++) begin
      p.sub[k] = mk_fail();
    end

    if (m == 4'd0 || (kind == KIND_TRI && cgiven)) begin
      p.last_idx = 2'd0;
    end else if (kind == KIND_TRI) begin
      unique case (cnt)
        3'd1: begin
          n = lo_set;
          b = inc3(n);
          a = inc3(b);
          p.sub[0]   = mk_tri(src_v(a), src_v(n), src_e(n));
          p.sub[1]   = mk_tri(src_v(a), src_e(n), src_v(b));
          p.last_idx = 2'd1;
        end
        3'd2: begin
          a = inc3(lo_clr);
          b = inc3(a);
          p.sub[0]   = mk_tri(src_e(a), src_v(b), src_e(b));
          p.sub[1]   = mk_quad(src_v(lo_clr), src_v(a), src_e(a), src_e(b), 1'b0);
          p.last_idx = 2'd1;
        end
        default: begin
          p.sub[0]   = mk_tri(src_v(2'd0), src_e(2'd0), src_e(2'd2));
          p.sub[1]   = mk_tri(src_v(2'd1), src_e(2'd1), src_e(2'd0));
          p.sub[2]   = mk_tri(src_v(2'd2), src_e(2'd2), src_e(2'd1));
          p.sub[3]   = mk_tri(src_e(2'd0), src_e(2'd1), src_e(2'd2));
          p.last_idx = 2'd3;
        end
      endcase
    end else begin
      unique case (cnt)
        3'd1: begin
          s  = 2'(lo_set + 2'd3);
          c0 = src_v(s);
          c1 = src_v(2'(s + 2'd1));
          c2 = src_v(2'(s + 2'd2));
          c3 = src_v(2'(s + 2'd3));
          x  = src_e(lo_set);
          p.sub[0]   = mk_tri(c0, c1, x);
          p.sub[1]   = mk_tri(c0, x, c3);
          p.sub[2]   = mk_tri(c3, x, c2);
          p.last_idx = 2'd2;
        end
        3'd2: begin
          i0 = lo_set;
          i1 = hi_set;
          // The pair of edges 3 and 0 wraps around, so edge 3 leads.
          if (i0 == 2'd0 && i1 == 2'd3) begin
            i0 = 2'd3;
            i1 = 2'd0;
          end
          opp = (m == 4'b0101) || (m == 4'b1010);
          s  = 2'(i0 + 2'd3);
          c0 = src_v(s);
          c1 = src_v(2'(s + 2'd1));
          c2 = src_v(2'(s + 2'd2));
          c3 = src_v(2'(s + 2'd3));
          x  = src_e(i0);
          y  = src_e(i1);
          if (opp) begin
            p.sub[0]   = mk_quad(c0, c1, x, y, 1'b0);
            p.sub[1]   = mk_quad(y, x, c2, c3, 1'b0);
            p.last_idx = 2'd1;
          end else begin
            p.sub[0]   = mk_tri(c0, c1, x);
            p.sub[1]   = mk_tri(x, c2, y);
            p.sub[2]   = mk_tri(c3, c0, y);
            p.sub[3]   = mk_tri(c0, x, y);
            p.last_idx = 2'd3;
          end
        end
        3'd3: begin
          s  = 2'(lo_clr + 2'd1);
          c0 = src_v(s);
          c1 = src_v(2'(s + 2'd1));
          c2 = src_v(2'(s + 2'd2));
          c3 = src_v(2'(s + 2'd3));
          x  = src_e(2'(lo_clr + 2'd1));
          y  = src_e(2'(lo_clr + 2'd2));
          z  = src_e(2'(lo_clr + 2'd3));
          p.sub[0]   = mk_quad(c0, x, z, c3, 1'b0);
          p.sub[1]   = mk_tri(c1, y, x);
          p.sub[2]   = mk_tri(c2, z, y);
          p.sub[3]   = mk_tri(x, y, z);
          p.last_idx = 2'd3;
        end
        default: begin
          p.sub[0]   = mk_quad(src_v(2'd0), src_e(2'd0), SRC_CTR, src_e(2'd3), 1'b1);
          p.sub[1]   = mk_quad(src_v(2'd1), src_e(2'd1), SRC_CTR, src_e(2'd0), 1'b1);
          p.sub[2]   = mk_quad(src_v(2'd2), src_e(2'd2), SRC_CTR, src_e(2'd1), 1'b1);
          p.sub[3]   = mk_quad(src_v(2'd3), src_e(2'd3), SRC_CTR, src_e(2'd2), 1'b1);
          p.last_idx = 2'd3;
        end
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/face_refinement_pattern_generator_core.sv
// Channel   Direction  Handshake              Payload
// input     in         in_valid_i/in_stall_o  kind, corners, edge vertices, mask, center
// result    out        out_valid_o/out_stall_i sub-face vertices, kind, flags, last
//
// A face yields one to four sub-faces; the back end emits one sub-face per cycle while
// the result channel is not stalled. The first result of a face is written to the queue
// and then to the output register before it is presented. A two-entry queue between
// classifier and emitter lets new faces enter while earlier sub-faces drain.
// Reset empties the queue and the output register; no clearing pass is needed.
// A stalled result holds in the output register while the queue takes faces until full.
`default_nettype none

module face_refinement_pattern_generator_core import frpg_pkg::*; #(
  parameter int unsigned VERTEX_ID_BITS = VERTEX_ID_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic                      kind_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner0_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner1_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner2_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner3_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex0_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex1_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex2_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex3_i,
  input  wire logic [3:0]                edge_refined_i,
  input  wire logic [VERTEX_ID_BITS-1:0] center_vertex_i,
  input  wire logic                      center_given_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      face_is_quad_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex0_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex1_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex2_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex3_o,
  output      logic                      center_used_o,
  output      logic                      status_o,
  output      logic                      last_o
);

  localparam int unsigned ENTRY_BITS = PLAN_BITS + 9 * VERTEX_ID_BITS;

  logic                  push;
  logic                  queue_full;
  logic [ENTRY_BITS-1:0] entry;
  logic                  head_valid;
  logic [ENTRY_BITS-1:0] head_data;
  logic                  pop;

  frpg_front #(
    .VERTEX_ID_BITS (VERTEX_ID_BITS),
    .ENTRY_BITS     (ENTRY_BITS)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .corner0_i       (corner0_i),
    .corner1_i       (corner1_i),
    .corner2_i       (corner2_i),
    .corner3_i       (corner3_i),
    .edge_vertex0_i  (edge_vertex0_i),
    .edge_vertex1_i  (edge_vertex1_i),
    .edge_vertex2_i  (edge_vertex2_i),
    .edge_vertex3_i  (edge_vertex3_i),
    .edge_refined_i  (edge_refined_i),
    .center_vertex_i (center_vertex_i),
    .center_given_i  (center_given_i),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .entry_o         (entry)
  );

  frpg_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  frpg_back #(
    .VERTEX_ID_BITS (VERTEX_ID_BITS),
    .ENTRY_BITS     (ENTRY_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_data_i    (head_data),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .face_is_quad_o (face_is_quad_o),
    .out_vertex0_o  (out_vertex0_o),
    .out_vertex1_o  (out_vertex1_o),
    .out_vertex2_o  (out_vertex2_o),
    .out_vertex3_o  (out_vertex3_o),
    .center_used_o  (center_used_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  // A failure is always the only result of its face.
  a_fail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o)
    else $error("failure result without last");

  a_center_on_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && center_used_o |-> face_is_quad_o && !status_o)
    else $error("center used on a non-quad result");

  a_tri_fourth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !face_is_quad_o |-> out_vertex3_o == '0)
    else $error("triangle with nonzero fourth vertex");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> out_vertex0_o == '0 && !face_is_quad_o)
    else $error("failure result carries vertex data");

endmodule

`default_nettype wire

### rtl/frpg_front.sv
`default_nettype none

module frpg_front import frpg_pkg::*; #(
  parameter int unsigned VERTEX_ID_BITS = VERTEX_ID_BITS_DEF,
  parameter int unsigned ENTRY_BITS     = PLAN_BITS + 9 * VERTEX_ID_BITS
) (
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic                      kind_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner0_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner1_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner2_i,
  input  wire logic [VERTEX_ID_BITS-1:0] corner3_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex0_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex1_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex2_i,
  input  wire logic [VERTEX_ID_BITS-1:0] edge_vertex3_i,
  input  wire logic [3:0]                edge_refined_i,
  input  wire logic [VERTEX_ID_BITS-1:0] center_vertex_i,
  input  wire logic                      center_given_i,
  input  wire logic                      queue_full_i,
  output      logic                      push_o,
  output      logic [ENTRY_BITS-1:0]     entry_o
);

  plan_t plan;

  assign plan       = plan_f(kind_i, edge_refined_i, center_given_i);
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;
  assign entry_o    = {plan, center_vertex_i,
                       edge_vertex3_i, edge_vertex2_i, edge_vertex1_i, edge_vertex0_i,
                       corner3_i, corner2_i, corner1_i, corner0_i};

endmodule

`default_nettype wire

### rtl/frpg_queue.sv
`default_nettype none

module frpg_queue import frpg_pkg::*; #(
  parameter int unsigned WIDTH = PLAN_BITS,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic             head_valid_o,
  output      logic [WIDTH-1:0] head_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ptr_inc(wr_q) : wr_q;
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/frpg_back.sv
`default_nettype none

module frpg_back import frpg_pkg::*; #(
  parameter int unsigned VERTEX_ID_BITS = VERTEX_ID_BITS_DEF,
  parameter int unsigned ENTRY_BITS     = PLAN_BITS + 9 * VERTEX_ID_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      head_valid_i,
  input  wire logic [ENTRY_BITS-1:0]     head_data_i,
  output      logic                      pop_o,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      face_is_quad_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex0_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex1_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex2_o,
  output      logic [VERTEX_ID_BITS-1:0] out_vertex3_o,
  output      logic                      center_used_o,
  output      logic                      status_o,
  output      logic                      last_o
);

  localparam int unsigned W = VERTEX_ID_BITS;

  logic [W-1:0] corner [4];
  logic [W-1:0] edge_v [4];
  logic [W-1:0] ctr;
  plan_t        plan;
  sub_t         cur;
  logic         load;
  logic         is_last;

  logic [1:0]   sub_q, sub_d;
  logic         valid_q, valid_d;
  logic         quad_q;
  logic         cu_q;
  logic         status_q;
  logic         last_q;
  logic [W-1:0] vtx_q [4];

  function automatic logic [W-1:0] pick(input src_t s);
    logic [W-1:0] r;
    unique case (s)
      SRC_V_BASE:                  r = corner[0];
      SRC_V_BASE | 4'd1:           r = corner[1];
      SRC_V_BASE | 4'd2:           r = corner[2];
      SRC_V_BASE | 4'd3:           r = corner[3];
      SRC_E_BASE:                  r = edge_v[0];
      SRC_E_BASE | 4'd1:           r = edge_v[1];
      SRC_E_BASE | 4'd2:           r = edge_v[2];
      SRC_E_BASE | 4'd3:           r = edge_v[3];
      SRC_CTR:                     r = ctr;
      default:                     r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      corner[k] = head_data_i[k*W +: W];
      edge_v[k] = head_data_i[(4+k)*W +: W];
    end
  end

  assign ctr     = head_data_i[8*W +: W];
  assign plan    = plan_t'(head_data_i[9*W +: PLAN_BITS]);
  assign cur     = plan.sub[sub_q];
  assign is_last = (sub_q == plan.last_idx);

  // The output register takes the next sub-face whenever it is empty or being drained.
  assign load  = head_valid_i && (!valid_q || !out_stall_i);
  assign pop_o = load && is_last;

  always_comb begin
    sub_d   = sub_q;
    if (load) begin
      sub_d = is_last ? 2'd0 : 2'(sub_q + 2'd1);
    end
    valid_d = load || (valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quad_q   <= cur.quad;
      cu_q     <= cur.center_used;
      status_q <= cur.status;
      last_q   <= is_last;
      for (int k = 0; k < 4; k++) begin
        vtx_q[k] <= pick(cur.src[k]);
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign face_is_quad_o = quad_q;
  assign out_vertex0_o  = vtx_q[0];
  assign out_vertex1_o  = vtx_q[1];
  assign out_vertex2_o  = vtx_q[2];
  assign out_vertex3_o  = vtx_q[3];
  assign center_used_o  = cu_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

### bench/subface_checker.sv
`timescale 1ns / 100ps

module subface_checker import frpg_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          kind_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] corner0_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] corner1_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] corner2_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] corner3_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] edge_vertex0_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] edge_vertex1_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] edge_vertex2_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] edge_vertex3_i,
  input  logic [3:0]                    edge_refined_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] center_vertex_i,
  input  logic                          center_given_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          face_is_quad_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] out_vertex0_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] out_vertex1_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] out_vertex2_i,
  input  logic [VERTEX_ID_BITS_DEF-1:0] out_vertex3_i,
  input  logic                          center_used_i,
  input  logic                          status_i,
  input  logic                          last_i,
  output int                            mismatches_o,
  output int                            pending_o
);

  localparam int VW = VERTEX_ID_BITS_DEF;

  typedef logic [VW-1:0] vid_t;

  typedef struct packed {
    logic       quad;
    vid_t [3:0] vtx;
    logic       center_used;
    logic       status;
    logic       last;
  } subface_t;

  subface_t subface_q[$];
  int       mismatches = 0;
  int       pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  function automatic subface_t make_tri(input vid_t a, input vid_t b, input vid_t c);
    subface_t r;
    r             = '0;
    r.vtx[0]      = a;
    r.vtx[1]      = b;
    r.vtx[2]      = c;
    return r;
  endfunction

  function automatic subface_t make_quad(input vid_t a, input vid_t b, input vid_t c,
                                         input vid_t d, input logic cu);
    subface_t r;
    r             = '0;
    r.quad        = 1'b1;
    r.vtx[0]      = a;
    r.vtx[1]      = b;
    r.vtx[2]      = c;
    r.vtx[3]      = d;
    r.center_used = cu;
    return r;
  endfunction

  // Splits one face into its sub-faces and queues them in emission order.
  function automatic void predict_subfaces();
    vid_t       v[4];
    vid_t       e[4];
    vid_t       c[4];
    subface_t   sub[4];
    logic [3:0] m;
    int         cnt;
    int         nsub;
    int         idx[4];
    int         k;
    int         s;
    int         f;
    int         n;
    int         tmp;

    v = '{corner0_i, corner1_i, corner2_i, corner3_i};
    e = '{edge_vertex0_i, edge_vertex1_i, edge_vertex2_i, edge_vertex3_i};
    m = (kind_i == KIND_QUAD) ? edge_refined_i : {1'b0, edge_refined_i[2:0]};
    cnt  = $countones(m);
    nsub = 0;
    s    = 0;
    f    = 0;
    idx  = '{0, 0, 0, 0};

    if (m == 4'd0 || (kind_i == KIND_TRI && center_given_i)) begin
      sub[0]        = '0;
      sub[0].status = 1'b1;
      nsub          = 1;
    end else if (kind_i == KIND_TRI) begin
      case (cnt)
        1: begin
          n = m[0] ? 0 : (m[1] ? 1 : 2);
          sub[0] = make_tri(v[(n + 2) % 3], v[n], e[n]);
          sub[1] = make_tri(v[(n + 2) % 3], e[n], v[(n + 1) % 3]);
          nsub   = 2;
        end
        2: begin
          f = !m[0] ? 0 : (!m[1] ? 1 : 2);
          sub[0] = make_tri(e[(f + 1) % 3], v[(f + 2) % 3], e[(f + 2) % 3]);
          sub[1] = make_quad(v[f], v[(f + 1) % 3], e[(f + 1) % 3], e[(f + 2) % 3], 1'b0);
          nsub   = 2;
        end
        default: begin
          sub[0] = make_tri(v[0], e[0], e[2]);
          sub[1] = make_tri(v[1], e[1], e[0]);
          sub[2] = make_tri(v[2], e[2], e[1]);
          sub[3] = make_tri(e[0], e[1], e[2]);
          nsub   = 4;
        end
      endcase
    end else begin
      n = 0;
      for (k = 0; k < 4; k++) begin
        if (m[k]) begin
          idx[n] = k;
          n++;
        end
      end
      if (cnt == 1) begin
        s = (idx[0] + 3) % 4;
      end else if (cnt == 2) begin
        // Edges 3 and 0 are adjacent across the wrap, so edge 3 comes first.
        if (idx[0] == 0 && idx[1] == 3) begin
          tmp    = idx[0];
          idx[0] = idx[1];
          idx[1] = tmp;
        end
        s = (idx[0] + 3) % 4;
      end else if (cnt == 3) begin
        f = !m[0] ? 0 : (!m[1] ? 1 : (!m[2] ? 2 : 3));
        s = (f + 1) % 4;
      end
      for (k = 0; k < 4; k++) begin
        c[k] = v[(s + k) % 4];
      end
      case (cnt)
        1: begin
          sub[0] = make_tri(c[0], c[1], e[idx[0]]);
          sub[1] = make_tri(c[0], e[idx[0]], c[3]);
          sub[2] = make_tri(c[3], e[idx[0]], c[2]);
          nsub   = 3;
        end
        2: begin
          if (idx[1] - idx[0] == 2) begin
            sub[0] = make_quad(c[0], c[1], e[idx[0]], e[idx[1]], 1'b0);
            sub[1] = make_quad(e[idx[1]], e[idx[0]], c[2], c[3], 1'b0);
            nsub   = 2;
          end else begin
            sub[0] = make_tri(c[0], c[1], e[idx[0]]);
            sub[1] = make_tri(e[idx[0]], c[2], e[idx[1]]);
            sub[2] = make_tri(c[3], c[0], e[idx[1]]);
            sub[3] = make_tri(c[0], e[idx[0]], e[idx[1]]);
            nsub   = 4;
          end
        end
        3: begin
          sub[0] = make_quad(c[0], e[(f + 1) % 4], e[(f + 3) % 4], c[3], 1'b0);
          sub[1] = make_tri(c[1], e[(f + 2) % 4], e[(f + 1) % 4]);
          sub[2] = make_tri(c[2], e[(f + 3) % 4], e[(f + 2) % 4]);
          sub[3] = make_tri(e[(f + 1) % 4], e[(f + 2) % 4], e[(f + 3) % 4]);
          nsub   = 4;
        end
        default: begin
          // The center id is taken as given, whether or not the caller flagged it.
          for (k = 0; k < 4; k++) begin
            sub[k] = make_quad(v[k], e[k], center_vertex_i, e[(k + 3) % 4], 1'b1);
          end
          nsub = 4;
        end
      endcase
    end

    for (k = 0; k < nsub; k++) begin
      sub[k].last = (k == nsub - 1);
      subface_q   = {subface_q, sub[k]};
    end
  endfunction

  task automatic check_field(input string name, input vid_t want, input vid_t got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    subface_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        predict_subfaces();
      end
      if (out_valid_i && !out_stall_i) begin
        if (subface_q.size() == 0) begin
          $error("result transfer with no sub-face expected");
          mismatches++;
        end else begin
          want = subface_q.pop_front();
          check_field("face_is_quad", vid_t'(want.quad), vid_t'(face_is_quad_i));
          check_field("out_vertex0", want.vtx[0], out_vertex0_i);
          check_field("out_vertex1", want.vtx[1], out_vertex1_i);
          check_field("out_vertex2", want.vtx[2], out_vertex2_i);
          check_field("out_vertex3", want.vtx[3], out_vertex3_i);
          check_field("center_used", vid_t'(want.center_used), vid_t'(center_used_i));
          check_field("status", vid_t'(want.status), vid_t'(status_i));
          check_field("last", vid_t'(want.last), vid_t'(last_i));
        end
      end
      pending = subface_q.size();
    end
  end

endmodule

### bench/tb_face_refinement_pattern_generator_core.sv
`timescale 1ns / 100ps

module tb_face_refinement_pattern_generator_core import frpg_pkg::*;;

  localparam int VW = VERTEX_ID_BITS_DEF;
  localparam int RANDOM_FACES = 173;

  typedef logic [VW-1:0] vid_t;

  typedef struct {
    logic       kind;
    vid_t       corner[4];
    vid_t       edge_v[4];
    logic [3:0] mask;
    vid_t       center;
    logic       cgiven;
  } face_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       kind_i = KIND_TRI;
  vid_t       corner0_i = '0;
  vid_t       corner1_i = '0;
  vid_t       corner2_i = '0;
  vid_t       corner3_i = '0;
  vid_t       edge_vertex0_i = '0;
  vid_t       edge_vertex1_i = '0;
  vid_t       edge_vertex2_i = '0;
  vid_t       edge_vertex3_i = '0;
  logic [3:0] edge_refined_i = '0;
  vid_t       center_vertex_i = '0;
  logic       center_given_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       face_is_quad_o;
  vid_t       out_vertex0_o;
  vid_t       out_vertex1_o;
  vid_t       out_vertex2_o;
  vid_t       out_vertex3_o;
  logic       center_used_o;
  logic       status_o;
  logic       last_o;

  int mismatches;
  int pending;

  always #5 clk_i = ~clk_i;

  face_refinement_pattern_generator_core #(
    .VERTEX_ID_BITS(VW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .corner0_i      (corner0_i),
    .corner1_i      (corner1_i),
    .corner2_i      (corner2_i),
    .corner3_i      (corner3_i),
    .edge_vertex0_i (edge_vertex0_i),
    .edge_vertex1_i (edge_vertex1_i),
    .edge_vertex2_i (edge_vertex2_i),
    .edge_vertex3_i (edge_vertex3_i),
    .edge_refined_i (edge_refined_i),
    .center_vertex_i(center_vertex_i),
    .center_given_i (center_given_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .face_is_quad_o (face_is_quad_o),
    .out_vertex0_o  (out_vertex0_o),
    .out_vertex1_o  (out_vertex1_o),
    .out_vertex2_o  (out_vertex2_o),
    .out_vertex3_o  (out_vertex3_o),
    .center_used_o  (center_used_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  subface_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .corner0_i      (corner0_i),
    .corner1_i      (corner1_i),
    .corner2_i      (corner2_i),
    .corner3_i      (corner3_i),
    .edge_vertex0_i (edge_vertex0_i),
    .edge_vertex1_i (edge_vertex1_i),
    .edge_vertex2_i (edge_vertex2_i),
    .edge_vertex3_i (edge_vertex3_i),
    .edge_refined_i (edge_refined_i),
    .center_vertex_i(center_vertex_i),
    .center_given_i (center_given_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .face_is_quad_i (face_is_quad_o),
    .out_vertex0_i  (out_vertex0_o),
    .out_vertex1_i  (out_vertex1_o),
    .out_vertex2_i  (out_vertex2_o),
    .out_vertex3_i  (out_vertex3_o),
    .center_used_i  (center_used_o),
    .status_i       (status_o),
    .last_i         (last_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  // Directed faces cycle through near-max ids, small ids and random ids.
  function automatic face_t directed_face(input logic kind, input logic [3:0] mask,
                                          input logic cgiven, input int style);
    face_t f;
    f.kind   = kind;
    f.mask   = mask;
    f.cgiven = cgiven;
    for (int k = 0; k < 4; k++) begin
      case (style % 3)
        0: begin
          f.corner[k] = ~vid_t'(k);
          f.edge_v[k] = ~vid_t'(4 + k);
        end
        1: begin
          f.corner[k] = vid_t'(k);
          f.edge_v[k] = vid_t'(4 + k);
        end
        default: begin
          f.corner[k] = vid_t'($urandom);
          f.edge_v[k] = vid_t'($urandom);
        end
      endcase
    end
    f.center = (style % 3 == 0) ? ~vid_t'(8) : ((style % 3 == 1) ? vid_t'(8) : vid_t'($urandom));
    return f;
  endfunction

  // Mostly faces that refine; the rest fail on an empty mask or a triangle center.
  function automatic face_t random_face();
    face_t f;
    int    r;
    r        = $urandom_range(0, 99);
    f.kind   = 1'($urandom_range(0, 1));
    f.center = vid_t'($urandom);
    for (int k = 0; k < 4; k++) begin
      f.corner[k] = vid_t'($urandom);
      f.edge_v[k] = vid_t'($urandom);
    end
    if (r < 85) begin
      if (f.kind == KIND_TRI) begin
        f.mask   = {1'($urandom_range(0, 1)), 3'($urandom_range(1, 7))};
        f.cgiven = 1'b0;
      end else begin
        f.mask   = 4'($urandom_range(1, 15));
        f.cgiven = 1'($urandom_range(0, 1));
      end
    end else if (r < 92) begin
      f.mask   = 4'd0;
      f.cgiven = 1'($urandom_range(0, 1));
    end else if (r < 97) begin
      f.kind   = KIND_TRI;
      f.mask   = 4'($urandom_range(0, 15));
      f.cgiven = 1'b1;
    end else begin
      f.kind   = KIND_TRI;
      f.mask   = 4'b1000;
      f.cgiven = 1'b0;
    end
    return f;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic put_face(input face_t f);
    in_valid_i      <= 1'b1;
    kind_i          <= f.kind;
    corner0_i       <= f.corner[0];
    corner1_i       <= f.corner[1];
    corner2_i       <= f.corner[2];
    corner3_i       <= f.corner[3];
    edge_vertex0_i  <= f.edge_v[0];
    edge_vertex1_i  <= f.edge_v[1];
    edge_vertex2_i  <= f.edge_v[2];
    edge_vertex3_i  <= f.edge_v[3];
    edge_refined_i  <= f.mask;
    center_vertex_i <= f.center;
    center_given_i  <= f.cgiven;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin : receiver
    int  len;
    int  cyc;
    bit  pressed;
    cyc     = 0;
    pressed = 1'b0;
    @(posedge rst_ni);
    forever begin
      len = $urandom_range(0, 15);
      repeat (len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
        cyc++;
      end
      // One long hold-off so the queue fills and the block stalls its input.
      if (!pressed && cyc >= 400) begin
        pressed = 1'b1;
        len     = 200;
      end else begin
        len = ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(15, 50);
      end
      repeat (len) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        cyc++;
      end
    end
  end

  initial begin : stimulus
    int drain;
    int style;
    style = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int m = 0; m < 9; m++) begin
      put_face(directed_face(KIND_TRI, 4'(m), 1'b0, style++));
      sender_gap();
    end
    put_face(directed_face(KIND_TRI, 4'b0111, 1'b1, style++));
    sender_gap();
    for (int m = 0; m < 16; m++) begin
      put_face(directed_face(KIND_QUAD, 4'(m), 1'(m[0] ^ m[2]), style++));
      sender_gap();
    end
    put_face(directed_face(KIND_QUAD, 4'b1111, 1'b1, style++));
    sender_gap();

    for (int i = 0; i < RANDOM_FACES; i++) begin
      put_face(random_face());
      sender_gap();
    end
    in_valid_i <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 50000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
rtl/frpg_pkg.sv
rtl/frpg_front.sv
rtl/frpg_queue.sv
rtl/frpg_back.sv
rtl/face_refinement_pattern_generator_core.sv
bench/subface_checker.sv
bench/tb_face_refinement_pattern_generator_core.sv
